>>> hw/rtl/at_ipd_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// at_ipd_frame_parser_defines
// assertion macros of the frame parser checker
// ----------------------------------------------------------------------------
`ifndef AT_IPD_FRAME_PARSER_DEFINES_SVH
`define AT_IPD_FRAME_PARSER_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define AIPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define AIPD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/aipd_pkg.sv
// ----------------------------------------------------------------------------
// aipd_pkg
// types, character codes and helpers of the ipd frame parser
// ----------------------------------------------------------------------------
package aipd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_HEADER   = 2'd1,
        MODE_PAYLOAD  = 2'd2,
        MODE_COMPLETE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_HEADER   = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_ERROR    = 3'd4
    } t_status;

    // per field: a digit was seen, and the value went out of range
    typedef struct packed {
        logic bad;
        logic digit;
    } t_flags;

    localparam logic CFG_MAX_ID  = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    localparam logic [2:0]  PREFIX_LEN = 3'd5;
    localparam logic [19:0] VALUE_CAP  = 20'd65535;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // expected byte at each prefix position of "+IPD,"
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_PLUS;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = CH_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/aipd_dec_acc.sv
// ----------------------------------------------------------------------------
// aipd_dec_acc
// one decimal digit step of a running field accumulator with overflow flag
// ----------------------------------------------------------------------------
module aipd_dec_acc
    import aipd_pkg::*;
(
    input  logic [15:0] i_acc,
    input  t_flags      i_flags,
    input  logic [3:0]  i_digit,
    output logic [15:0] o_acc,
    output t_flags      o_flags
);

    logic [19:0] sum;

    // acc * 10 + digit
    assign sum = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + {16'd0, i_digit};

    always_comb begin
        o_acc         = i_acc;
        o_flags       = i_flags;
        o_flags.digit = 1'b1;
        if (!i_flags.bad) begin
            if (sum > VALUE_CAP) begin
                o_flags.bad = 1'b1;
            end else begin
                o_acc = sum[15:0];
            end
        end
    end

endmodule

>>> hw/rtl/at_ipd_frame_parser.sv
// ----------------------------------------------------------------------------
// at_ipd_frame_parser
// byte parser for "+IPD,<id>,<length>:" headers with payload countdown
// ----------------------------------------------------------------------------
// a byte passes the input register, then the result register, before its result is valid
// throughput: one byte per cycle while the result register is free or drains
// an input register in front of the result register lets a byte in while a
// result waits; reset clears parser state, handshakes and config to defaults
// ----------------------------------------------------------------------------
module at_ipd_frame_parser
    import aipd_pkg::*;
#(
    parameter int HEADER_LIMIT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // byte in
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // result out
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_conn_id,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_completed_length
);

    // header count runs up to HEADER_LIMIT-1
    localparam int CNT_W = $clog2(HEADER_LIMIT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEADER_LIMIT - 1);

    // config registers
    logic [15:0] r_max_id;
    logic [15:0] r_max_len;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parser state
    t_mode       r_mode,    n_mode;
    logic [2:0]  r_ppos,    n_ppos;
    logic [CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic        r_comma,   n_comma;
    logic [15:0] r_id_acc,  n_id_acc;
    t_flags      r_id_flags, n_id_flags;
    logic [15:0] r_len_acc, n_len_acc;
    t_flags      r_len_flags, n_len_flags;
    logic [15:0] r_rem,     n_rem;
    logic [15:0] r_last_id, n_last_id;
    logic [15:0] r_last_len, n_last_len;

    // result register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [15:0] r_out_id;
    logic [15:0] r_out_len;
    logic [15:0] r_out_done;

    t_status     step_status;
    logic [15:0] step_done;

    logic        rx_accept;
    logic        s1_adv;

    logic        is_decimal;
    logic        is_comma;
    logic        is_colon;
    logic        close_ok;

    logic [15:0] id_acc_step;
    t_flags      id_flags_step;
    logic [15:0] len_acc_step;
    t_flags      len_flags_step;

    // handshake: stage 1 moves when the result register is free or drains
    assign s1_adv     = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || s1_adv;
    assign rx_accept  = i_rx_valid && o_rx_ready;

    // byte classes
    assign is_decimal = r_in_byte inside {[CH_ZERO:CH_NINE]};
    assign is_comma   = (r_in_byte == CH_COMMA);
    assign is_colon   = (r_in_byte == CH_COLON);

    // digit steps for both fields, one of them is taken
    aipd_dec_acc u_id_acc (
        .i_acc   (r_id_acc),
        .i_flags (r_id_flags),
        .i_digit (r_in_byte[3:0]),
        .o_acc   (id_acc_step),
        .o_flags (id_flags_step)
    );

    aipd_dec_acc u_len_acc (
        .i_acc   (r_len_acc),
        .i_flags (r_len_flags),
        .i_digit (r_in_byte[3:0]),
        .o_acc   (len_acc_step),
        .o_flags (len_flags_step)
    );

    // header close check: comma, clean nonempty fields, within limits
    assign close_ok = r_comma
                   && r_id_flags.digit && !r_id_flags.bad && (r_id_acc <= r_max_id)
                   && r_len_flags.digit && !r_len_flags.bad && (r_len_acc <= r_max_len);

    // next state and result of the byte in the input register
    always_comb begin
        n_mode      = r_mode;
        n_ppos      = r_ppos;
        n_hdr_cnt   = r_hdr_cnt;
        n_comma     = r_comma;
        n_id_acc    = r_id_acc;
        n_id_flags  = r_id_flags;
        n_len_acc   = r_len_acc;
        n_len_flags = r_len_flags;
        n_rem       = r_rem;
        n_last_id   = r_last_id;
        n_last_len  = r_last_len;
        step_status = ST_IDLE;

        // a finished frame: this byte starts a fresh hunt
        if (r_mode == MODE_COMPLETE) begin
            n_mode    = MODE_IDLE;
            n_hdr_cnt = '0;
            n_rem     = '0;
            n_ppos    = '0;
        end

        case (n_mode)
            MODE_IDLE: begin
                step_status = ST_IDLE;
                if (r_in_byte == prefix_char(n_ppos)) begin
                    n_ppos = n_ppos + 3'd1;
                    if (n_ppos == PREFIX_LEN) begin
                        n_mode      = MODE_HEADER;
                        n_hdr_cnt   = '0;
                        n_comma     = 1'b0;
                        n_id_acc    = '0;
                        n_id_flags  = '0;
                        n_len_acc   = '0;
                        n_len_flags = '0;
                    end
                end else begin
                    // restart, a '+' already counts as the first prefix byte
                    n_ppos = (r_in_byte == CH_PLUS) ? 3'd1 : 3'd0;
                end
            end
            MODE_HEADER: begin
                if (!(is_decimal || is_comma || is_colon) || (r_hdr_cnt >= CNT_LAST)) begin
                    n_mode      = MODE_IDLE;
                    n_hdr_cnt   = '0;
                    n_rem       = '0;
                    n_ppos      = '0;
                    step_status = ST_ERROR;
                end else begin
                    n_hdr_cnt   = r_hdr_cnt + CNT_W'(1);
                    step_status = ST_HEADER;
                    if (is_decimal) begin
                        if (r_comma) begin
                            n_len_acc   = len_acc_step;
                            n_len_flags = len_flags_step;
                        end else begin
                            n_id_acc    = id_acc_step;
                            n_id_flags  = id_flags_step;
                        end
                    end else if (is_comma) begin
                        // a second comma spoils the length field
                        if (r_comma) begin
                            n_len_flags.bad = 1'b1;
                        end
                        n_comma = 1'b1;
                    end else if (!close_ok) begin
                        n_mode      = MODE_IDLE;
                        n_hdr_cnt   = '0;
                        n_rem       = '0;
                        n_ppos      = '0;
                        step_status = ST_ERROR;
                    end else begin
                        n_last_id  = r_id_acc;
                        n_last_len = r_len_acc;
                        if (r_len_acc == 16'd0) begin
                            // empty payload completes on the colon
                            n_mode      = MODE_COMPLETE;
                            n_hdr_cnt   = '0;
                            n_rem       = '0;
                            n_ppos      = '0;
                            step_status = ST_COMPLETE;
                        end else begin
                            n_rem       = r_len_acc;
                            n_mode      = MODE_PAYLOAD;
                            step_status = ST_HEADER;
                        end
                    end
                end
            end
            MODE_PAYLOAD: begin
                if (r_rem == 16'd0) begin
                    // empty countdown, not reachable from a valid header
                    n_mode      = MODE_IDLE;
                    n_hdr_cnt   = '0;
                    n_rem       = '0;
                    n_ppos      = '0;
                    step_status = ST_ERROR;
                end else begin
                    n_rem = r_rem - 16'd1;
                    if (r_rem == 16'd1) begin
                        n_mode      = MODE_COMPLETE;
                        step_status = ST_COMPLETE;
                    end else begin
                        step_status = ST_PAYLOAD;
                    end
                end
            end
            default: begin
                n_mode      = MODE_IDLE;
                n_hdr_cnt   = '0;
                n_rem       = '0;
                n_ppos      = '0;
                step_status = ST_IDLE;
            end
        endcase

        step_done = (n_mode == MODE_COMPLETE) ? n_last_len : 16'd0;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_id  <= 16'd4;
            r_max_len <= 16'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_ID:  r_max_id  <= i_cfg_data;
                CFG_MAX_LEN: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_accept) begin
            r_in_valid <= 1'b1;
        end else if (s1_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_ppos      <= '0;
            r_hdr_cnt   <= '0;
            r_comma     <= 1'b0;
            r_id_acc    <= '0;
            r_id_flags  <= '0;
            r_len_acc   <= '0;
            r_len_flags <= '0;
            r_rem       <= '0;
            r_last_id   <= '0;
            r_last_len  <= '0;
        end else if (s1_adv) begin
            r_mode      <= n_mode;
            r_ppos      <= n_ppos;
            r_hdr_cnt   <= n_hdr_cnt;
            r_comma     <= n_comma;
            r_id_acc    <= n_id_acc;
            r_id_flags  <= n_id_flags;
            r_len_acc   <= n_len_acc;
            r_len_flags <= n_len_flags;
            r_rem       <= n_rem;
            r_last_id   <= n_last_id;
            r_last_len  <= n_last_len;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= step_status;
            r_out_id     <= n_last_id;
            r_out_len    <= n_last_len;
            r_out_done   <= step_done;
        end
    end

    assign o_res_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_conn_id          = r_out_id;
    assign o_payload_length   = r_out_len;
    assign o_completed_length = r_out_done;

endmodule

>>> hw/rtl/aipd_checker.sv
// ----------------------------------------------------------------------------
// aipd_checker
// port-level checks of the ipd frame parser, bound to the top level
// ----------------------------------------------------------------------------
`include "at_ipd_frame_parser_defines.svh"

module aipd_checker
    import aipd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [2:0]  o_status,
    input logic [15:0] o_conn_id,
    input logic [15:0] o_payload_length,
    input logic [15:0] o_completed_length
);

    // stalled result holds
    `AIPD_ASSERT(a_res_hold, o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_status) && $stable(o_conn_id) && $stable(o_payload_length) && $stable(o_completed_length), "result changed while stalled")

    // a nonzero completed length only comes with a complete status
    `AIPD_ASSERT(a_done_status, o_res_valid && (o_completed_length != 16'd0) |-> (o_status == ST_COMPLETE), "completed length without complete status")

    // a complete frame reports its own length
    `AIPD_ASSERT(a_done_len, o_res_valid && (o_status == ST_COMPLETE) |-> (o_completed_length == o_payload_length), "completed length differs from payload length")

    // no result right after reset
    `AIPD_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_res_valid, "result valid after reset")

endmodule

bind at_ipd_frame_parser aipd_checker u_aipd_checker (.*);
